// ===== hw/rtl/tree_ancestor_query_engine_assert.svh =====
// Assertion macros used by the engine's top-level RTL file.
// Define ASSERT_OFF to compile every check away.
`ifndef TREE_ANCESTOR_QUERY_ENGINE_ASSERT_SVH
`define TREE_ANCESTOR_QUERY_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/taqe_pkg.sv =====
// ----------------------------------------------------------------------------
// taqe_pkg
// Types, widths and codes of the tree ancestor query engine.
// ----------------------------------------------------------------------------
`default_nettype none

package taqe_pkg;

   localparam int NODE_BITS   = 14;
   localparam int NODE_COUNT  = 2 ** NODE_BITS;
   localparam int LIFT_LEVELS = 14;
   localparam int LVL_BITS    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int WEIGHT_BITS = 16;
   localparam int DEPTH_BITS  = NODE_BITS;
   localparam int DIST_BITS   = 30;
   localparam int POS_BITS    = 15;
   localparam int EPOCH_BITS  = 8;
   localparam int INFO_BITS   = DEPTH_BITS + DIST_BITS;
   localparam int ANC_ADDR_BITS = NODE_BITS + LVL_BITS;

   localparam logic [LVL_BITS-1:0]  LVL_TOP  = LVL_BITS'(LIFT_LEVELS - 1);
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_ATTACH = 2'd1;
   localparam logic [1:0] CMD_DIST   = 2'd2;
   localparam logic [1:0] CMD_KTH    = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_UNATTACHED = 2'd1;
   localparam logic [1:0] STATUS_RANGE      = 2'd2;

   typedef logic [NODE_BITS-1:0] node_type;

   typedef struct packed {
      logic     valid;
      node_type node;
   } anc_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_ROOT, S_ROOT_ROW, S_CHK_A, S_CHK_B,
      S_ATT_WRITE, S_ATT_RD, S_ATT_WR, S_INFO_B, S_ORDER, S_LIFT_RD,
      S_LIFT_CHK, S_SAME, S_CA_RDX, S_CA_RDY, S_CA_CMP, S_CA_PAR, S_CA_UP,
      S_INFO_X, S_FINAL, S_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_EPOCH, OP_ROOT, OP_ROOT_ROW, OP_MARK_A,
      OP_MARK_B, OP_INFO_A, OP_INFO_B, OP_ORDER, OP_ATT_WRITE, OP_ATT_RD,
      OP_ATT_WR, OP_LIFT_RD, OP_LIFT_CHK, OP_CA_INIT, OP_CA_RDX, OP_CA_RDY,
      OP_CA_CMP, OP_CA_PAR, OP_CA_UP, OP_INFO_X, OP_KTH_SET, OP_RESP
   } dp_op_type;

   typedef enum logic [2:0] {
      K_ZERO, K_ERR1, K_ERR2, K_DIST, K_NODE
   } kind_type;

   typedef enum logic {PH_EQ, PH_KTH} phase_type;

   typedef struct packed {
      dp_op_type op;
      kind_type  kind;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       hit;
      logic       lvl_zero;
      logic       lvl_last;
      logic       same;
      logic       pos_bad;
      logic       clr_last;
      logic       epoch_full;
      logic       busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/taqe_if.sv =====
// ----------------------------------------------------------------------------
// taqe_if
// Request and response channels of the tree ancestor query engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface taqe_req_if;
   import taqe_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             command;
   node_type               node_a;
   node_type               node_b;
   logic [WEIGHT_BITS-1:0] edge_weight;
   logic [POS_BITS-1:0]    path_position;

   modport source (output valid, command, node_a, node_b, edge_weight,
                   path_position, input ready);
   modport sink (input valid, command, node_a, node_b, edge_weight,
                 path_position, output ready);
endinterface

interface taqe_rsp_if;
   import taqe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] answer;
   logic [1:0]           status;

   modport source (output valid, answer, status, input ready);
   modport sink (input valid, answer, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/taqe_dp.sv =====
// ----------------------------------------------------------------------------
// taqe_dp
// Datapath: request latch, tree memories, walk registers and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module taqe_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire taqe_pkg::ctl_type               ctl,
   output      taqe_pkg::dp_status_type         sts,
   input  wire logic [1:0]                      req_command,
   input  wire taqe_pkg::node_type              req_node_a,
   input  wire taqe_pkg::node_type              req_node_b,
   input  wire logic [taqe_pkg::WEIGHT_BITS-1:0] req_edge_weight,
   input  wire logic [taqe_pkg::POS_BITS-1:0]   req_path_position,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [taqe_pkg::DIST_BITS-1:0]  rsp_answer,
   output      logic [1:0]                      rsp_status
);
   import taqe_pkg::*;

   // memories
   logic [EPOCH_BITS-1:0] mark_mem [NODE_COUNT];
   logic [INFO_BITS-1:0]  info_mem [NODE_COUNT];
   anc_type               anc_mem  [NODE_COUNT * (2 ** LVL_BITS)];

   logic [EPOCH_BITS-1:0]    mark_rd_ff;
   logic [INFO_BITS-1:0]     info_rd_ff;
   anc_type                  anc_rd_ff;

   logic                     mark_we, mark_re, info_we, info_re, anc_we, anc_re;
   node_type                 mark_waddr, mark_raddr, info_waddr, info_raddr;
   logic [EPOCH_BITS-1:0]    mark_wdata;
   logic [INFO_BITS-1:0]     info_wdata;
   logic [ANC_ADDR_BITS-1:0] anc_waddr, anc_raddr;
   anc_type                  anc_wdata;

   logic [1:0]             cmd_ff, cmd_in;
   node_type               na_ff, na_in, nb_ff, nb_in;
   logic [WEIGHT_BITS-1:0] wt_ff, wt_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   node_type               x_ff, x_in, y_ff, y_in;
   logic [DEPTH_BITS-1:0]  steps_ff, steps_in;
   logic [LVL_BITS-1:0]    lvl_ff, lvl_in;
   logic                   dead_ff, dead_in;
   anc_type                ex_ff, ex_in;
   logic [DEPTH_BITS-1:0]  da_ff, da_in, db_ff, db_in;
   logic [DIST_BITS-1:0]   ra_ff, ra_in, rb_ff, rb_in;
   logic [EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   node_type               cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS-1:0]   rsp_ans_ff, rsp_ans_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic [DEPTH_BITS-1:0]  rd_depth;
   logic [DIST_BITS-1:0]   rd_dist;
   logic [DIST_BITS:0]     att_sum;
   logic [DIST_BITS:0]     path_dist;
   logic [DEPTH_BITS-1:0]  up_a, up_b;
   logic [POS_BITS-1:0]    up_sum, path_len, k_pos;
   logic                   pos_bad;

   assign rd_depth = info_rd_ff[DIST_BITS +: DEPTH_BITS];
   assign rd_dist  = info_rd_ff[DIST_BITS-1:0];
   assign att_sum  = {1'b0, rd_dist} + (DIST_BITS+1)'(wt_ff);
   assign path_dist = {1'b0, ra_ff} + {1'b0, rb_ff} - {rd_dist, 1'b0};

   // path geometry for the k-th query, rd_depth being the meeting node's depth
   assign up_a     = da_ff - rd_depth;
   assign up_b     = db_ff - rd_depth;
   assign up_sum   = POS_BITS'(up_a) + POS_BITS'(up_b);
   assign path_len = up_sum + POS_BITS'(1);
   assign k_pos    = pos_ff - POS_BITS'(1);
   assign pos_bad  = (pos_ff == '0) || (pos_ff > path_len);

   always_comb begin
      cmd_in = cmd_ff;  na_in = na_ff;  nb_in = nb_ff;  wt_in = wt_ff;
      pos_in = pos_ff;  x_in = x_ff;  y_in = y_ff;  steps_in = steps_ff;
      lvl_in = lvl_ff;  dead_in = dead_ff;  ex_in = ex_ff;
      da_in = da_ff;  db_in = db_ff;  ra_in = ra_ff;  rb_in = rb_ff;
      epoch_in = epoch_ff;  cnt_in = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_ans_in    = rsp_ans_ff;
      rsp_status_in = rsp_status_ff;
      mark_we = 1'b0;  mark_waddr = na_ff;  mark_wdata = epoch_ff;
      mark_re = 1'b0;  mark_raddr = na_ff;
      info_we = 1'b0;  info_waddr = na_ff;  info_wdata = '0;
      info_re = 1'b0;  info_raddr = na_ff;
      anc_we = 1'b0;  anc_waddr = {na_ff, lvl_ff};  anc_wdata = '0;
      anc_re = 1'b0;  anc_raddr = {x_ff, lvl_ff};
      unique case (ctl.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            cmd_in = req_command;
            na_in  = req_node_a;
            nb_in  = req_node_b;
            wt_in  = req_edge_weight;
            pos_in = req_path_position;
         end
         OP_CLEAR: begin
            mark_we    = 1'b1;
            mark_waddr = cnt_ff;
            mark_wdata = '0;
            cnt_in     = cnt_ff + 1'b1;
            if (&cnt_ff) begin
               epoch_in = EPOCH_BITS'(1);
            end
         end
         OP_EPOCH: begin
            epoch_in = epoch_ff + 1'b1;
         end
         OP_ROOT: begin
            mark_we = 1'b1;
            info_we = 1'b1;
            lvl_in  = '0;
         end
         OP_ROOT_ROW: begin
            anc_we = 1'b1;
            lvl_in = lvl_ff + 1'b1;
         end
         OP_MARK_A: begin
            mark_re = 1'b1;
         end
         OP_MARK_B: begin
            mark_re    = 1'b1;
            mark_raddr = nb_ff;
         end
         OP_INFO_A: begin
            info_re = 1'b1;
         end
         OP_INFO_B: begin
            info_re    = 1'b1;
            info_raddr = nb_ff;
            da_in      = rd_depth;
            ra_in      = rd_dist;
         end
         OP_ORDER: begin
            db_in  = rd_depth;
            rb_in  = rd_dist;
            lvl_in = LVL_TOP;
            if (da_ff < rd_depth) begin
               x_in     = nb_ff;
               y_in     = na_ff;
               steps_in = rd_depth - da_ff;
            end else begin
               x_in     = na_ff;
               y_in     = nb_ff;
               steps_in = da_ff - rd_depth;
            end
         end
         OP_ATT_WRITE: begin
            info_we    = 1'b1;
            info_wdata = {rd_depth + 1'b1,
                          att_sum[DIST_BITS] ? DIST_MAX : att_sum[DIST_BITS-1:0]};
            mark_we    = 1'b1;
            anc_we     = 1'b1;
            anc_waddr  = {na_ff, LVL_BITS'(0)};
            anc_wdata  = '{valid: 1'b1, node: nb_ff};
            x_in       = nb_ff;
            lvl_in     = LVL_BITS'(1);
            dead_in    = 1'b0;
         end
         OP_ATT_RD: begin
            anc_re    = 1'b1;
            anc_raddr = {x_ff, lvl_ff - 1'b1};
         end
         OP_ATT_WR: begin
            anc_we    = 1'b1;
            anc_wdata = (dead_ff || !anc_rd_ff.valid) ? '0 : anc_rd_ff;
            if (!anc_rd_ff.valid) begin
               dead_in = 1'b1;
            end else begin
               x_in = anc_rd_ff.node;
            end
            lvl_in = lvl_ff + 1'b1;
         end
         OP_LIFT_RD, OP_CA_RDX: begin
            anc_re = 1'b1;
         end
         OP_LIFT_CHK: begin
            if (steps_ff[lvl_ff] && anc_rd_ff.valid) begin
               x_in = anc_rd_ff.node;
            end
            if (lvl_ff != '0) begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         OP_CA_INIT: begin
            lvl_in = LVL_TOP;
         end
         OP_CA_RDY: begin
            anc_re    = 1'b1;
            anc_raddr = {y_ff, lvl_ff};
            ex_in     = anc_rd_ff;
         end
         OP_CA_CMP: begin
            // climb both sides only where their ancestors still differ
            if (ex_ff != anc_rd_ff) begin
               if (ex_ff.valid) begin
                  x_in = ex_ff.node;
               end
               if (anc_rd_ff.valid) begin
                  y_in = anc_rd_ff.node;
               end
            end
            if (lvl_ff != '0) begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         OP_CA_PAR: begin
            anc_re    = 1'b1;
            anc_raddr = {x_ff, LVL_BITS'(0)};
         end
         OP_CA_UP: begin
            if (anc_rd_ff.valid) begin
               x_in = anc_rd_ff.node;
            end
         end
         OP_INFO_X: begin
            info_re    = 1'b1;
            info_raddr = x_ff;
         end
         OP_KTH_SET: begin
            lvl_in = LVL_TOP;
            if (k_pos <= POS_BITS'(up_a)) begin
               x_in     = na_ff;
               steps_in = k_pos[DEPTH_BITS-1:0];
            end else begin
               x_in     = nb_ff;
               steps_in = DEPTH_BITS'(up_sum - k_pos);
            end
         end
         OP_RESP: begin
            rsp_valid_in = 1'b1;
            unique case (ctl.kind)
               K_ZERO: begin
                  rsp_ans_in    = '0;
                  rsp_status_in = STATUS_OK;
               end
               K_ERR1: begin
                  rsp_ans_in    = '0;
                  rsp_status_in = STATUS_UNATTACHED;
               end
               K_ERR2: begin
                  rsp_ans_in    = '0;
                  rsp_status_in = STATUS_RANGE;
               end
               K_DIST: begin
                  rsp_ans_in    = path_dist[DIST_BITS] ? DIST_MAX
                                                       : path_dist[DIST_BITS-1:0];
                  rsp_status_in = STATUS_OK;
               end
               K_NODE: begin
                  rsp_ans_in    = DIST_BITS'(x_ff);
                  rsp_status_in = STATUS_OK;
               end
               default: begin
                  rsp_ans_in    = '0;
                  rsp_status_in = STATUS_OK;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (mark_re) begin
         mark_rd_ff <= mark_mem[mark_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[info_waddr] <= info_wdata;
      end
      if (info_re) begin
         info_rd_ff <= info_mem[info_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      if (anc_re) begin
         anc_rd_ff <= anc_mem[anc_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         epoch_ff     <= epoch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  na_ff <= na_in;  nb_ff <= nb_in;  wt_ff <= wt_in;
      pos_ff <= pos_in;  x_ff <= x_in;  y_ff <= y_in;  steps_ff <= steps_in;
      lvl_ff <= lvl_in;  dead_ff <= dead_in;  ex_ff <= ex_in;
      da_ff <= da_in;  db_ff <= db_in;  ra_ff <= ra_in;  rb_ff <= rb_in;
      rsp_ans_ff    <= rsp_ans_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      sts.cmd        = cmd_ff;
      sts.hit        = (mark_rd_ff == epoch_ff);
      sts.lvl_zero   = (lvl_ff == '0);
      sts.lvl_last   = (lvl_ff == LVL_TOP);
      sts.same       = (x_ff == y_ff);
      sts.pos_bad    = pos_bad;
      sts.clr_last   = &cnt_ff;
      sts.epoch_full = &epoch_ff;
      sts.busy       = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_ans_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/taqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// taqe_ctrl
// Controller: sequences memory reads, lifting passes and the response.
// ----------------------------------------------------------------------------
`default_nettype none

module taqe_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire taqe_pkg::dp_status_type sts,
   output      taqe_pkg::ctl_type       ctl
);
   import taqe_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   phase_type phase_ff, phase_in;
   logic      pend_ff, pend_in;
   logic      is_attach;

   assign is_attach = (sts.cmd == CMD_ATTACH);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) begin
               pend_in  = 1'b0;
               state_in = pend_ff ? S_ROOT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.cmd == CMD_START) begin
               if (sts.epoch_full) begin
                  pend_in  = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_ROOT;
               end
            end else begin
               state_in = S_CHK_A;
            end
         end
         S_ROOT: begin
            state_in = S_ROOT_ROW;
         end
         S_ROOT_ROW: begin
            if (sts.lvl_last) begin
               kind_in  = K_ZERO;
               state_in = S_RESP;
            end
         end
         S_CHK_A: begin
            // attach wants the child free, queries want the endpoint present
            if (is_attach ? sts.hit : !sts.hit) begin
               kind_in  = K_ERR1;
               state_in = S_RESP;
            end else begin
               state_in = S_CHK_B;
            end
         end
         S_CHK_B: begin
            if (!sts.hit) begin
               kind_in  = K_ERR1;
               state_in = S_RESP;
            end else begin
               state_in = is_attach ? S_ATT_WRITE : S_INFO_B;
            end
         end
         S_ATT_WRITE: begin
            if (LIFT_LEVELS == 1) begin
               kind_in  = K_ZERO;
               state_in = S_RESP;
            end else begin
               state_in = S_ATT_RD;
            end
         end
         S_ATT_RD: begin
            state_in = S_ATT_WR;
         end
         S_ATT_WR: begin
            if (sts.lvl_last) begin
               kind_in  = K_ZERO;
               state_in = S_RESP;
            end else begin
               state_in = S_ATT_RD;
            end
         end
         S_INFO_B: begin
            state_in = S_ORDER;
         end
         S_ORDER: begin
            phase_in = PH_EQ;
            state_in = S_LIFT_RD;
         end
         S_LIFT_RD: begin
            state_in = S_LIFT_CHK;
         end
         S_LIFT_CHK: begin
            if (!sts.lvl_zero) begin
               state_in = S_LIFT_RD;
            end else if (phase_ff == PH_KTH) begin
               kind_in  = K_NODE;
               state_in = S_RESP;
            end else begin
               state_in = S_SAME;
            end
         end
         S_SAME: begin
            state_in = sts.same ? S_FINAL : S_CA_RDX;
         end
         S_CA_RDX: begin
            state_in = S_CA_RDY;
         end
         S_CA_RDY: begin
            state_in = S_CA_CMP;
         end
         S_CA_CMP: begin
            state_in = sts.lvl_zero ? S_CA_PAR : S_CA_RDX;
         end
         S_CA_PAR: begin
            state_in = S_CA_UP;
         end
         S_CA_UP: begin
            state_in = S_INFO_X;
         end
         S_INFO_X: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (sts.cmd == CMD_DIST) begin
               kind_in  = K_DIST;
               state_in = S_RESP;
            end else if (sts.pos_bad) begin
               kind_in  = K_ERR2;
               state_in = S_RESP;
            end else begin
               phase_in = PH_KTH;
               state_in = S_LIFT_RD;
            end
         end
         S_RESP: begin
            if (!sts.busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.op    = OP_NONE;
      ctl.kind  = kind_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR:     ctl.op = OP_CLEAR;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op = OP_LOAD;
            end
         end
         S_DECODE: begin
            if (sts.cmd == CMD_START) begin
               if (!sts.epoch_full) begin
                  ctl.op = OP_EPOCH;
               end
            end else begin
               ctl.op = OP_MARK_A;
            end
         end
         S_ROOT:      ctl.op = OP_ROOT;
         S_ROOT_ROW:  ctl.op = OP_ROOT_ROW;
         S_CHK_A:     ctl.op = OP_MARK_B;
         S_CHK_B:     ctl.op = is_attach ? OP_INFO_B : OP_INFO_A;
         S_ATT_WRITE: ctl.op = OP_ATT_WRITE;
         S_ATT_RD:    ctl.op = OP_ATT_RD;
         S_ATT_WR:    ctl.op = OP_ATT_WR;
         S_INFO_B:    ctl.op = OP_INFO_B;
         S_ORDER:     ctl.op = OP_ORDER;
         S_LIFT_RD:   ctl.op = OP_LIFT_RD;
         S_LIFT_CHK:  ctl.op = OP_LIFT_CHK;
         S_SAME:      ctl.op = sts.same ? OP_INFO_X : OP_CA_INIT;
         S_CA_RDX:    ctl.op = OP_CA_RDX;
         S_CA_RDY:    ctl.op = OP_CA_RDY;
         S_CA_CMP:    ctl.op = OP_CA_CMP;
         S_CA_PAR:    ctl.op = OP_CA_PAR;
         S_CA_UP:     ctl.op = OP_CA_UP;
         S_INFO_X:    ctl.op = OP_INFO_X;
         S_FINAL: begin
            if (sts.cmd != CMD_DIST && !sts.pos_bad) begin
               ctl.op = OP_KTH_SET;
            end
         end
         S_RESP: begin
            if (!sts.busy) begin
               ctl.op = OP_RESP;
            end
         end
         default:     ctl.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         kind_ff  <= K_ZERO;
         phase_ff <= PH_EQ;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tree_ancestor_query_engine.sv =====
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine
// Weighted rooted tree kept as binary-lifting tables; answers path distance
// and k-th node on a path through the lowest common ancestor.
//
//   channel   dir   payload
//   req_ch    in    command, node_a, node_b, edge_weight, path_position
//   rsp_ch    out   answer, status
//
// One request at a time; each ancestor level is read from the ancestor
// memory and then used from the registered data. A query takes up to two
// lift passes and one common-ancestor pass.
// After reset, and on every 255th start, a clearing pass over all 16384
// nodes sweeps the attach marks; no request is taken meanwhile.
// A stalled response is held in its register; the next response waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tree_ancestor_query_engine_assert.svh"

module tree_ancestor_query_engine (
   input wire logic clock,
   input wire logic reset,
   taqe_req_if.sink   req_ch,
   taqe_rsp_if.source rsp_ch
);
   import taqe_pkg::*;

   ctl_type       ctl;
   dp_status_type sts;
   logic          req_ready;

   taqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   taqe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_ch.command),
      .req_node_a        (req_ch.node_a),
      .req_node_b        (req_ch.node_b),
      .req_edge_weight   (req_ch.edge_weight),
      .req_path_position (req_ch.path_position),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_answer        (rsp_ch.answer),
      .rsp_status        (rsp_ch.status)
   );

   assign req_ch.ready = req_ready;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_err_zero_answer, clock, reset, rsp_ch.valid && (rsp_ch.status != STATUS_OK), rsp_ch.answer == '0)
   `ASSERT_IMPLY(a_closed_in_clear, clock, reset, ctl.op == OP_CLEAR, !req_ready)

endmodule

`default_nettype wire

// ===== test/tree_ancestor_query_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_checker
// Watches the request and response channels of the tree ancestor query
// engine. It keeps its own copy of the lifting tables and computes the answer
// for every accepted request, then compares the responses in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query_engine_checker
   import taqe_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   taqe_req_if      req_ch,
   taqe_rsp_if      rsp_ch,
   output int       errors,
   output int       pending,
   output int       answered
);

   typedef struct packed {
      logic [DIST_BITS-1:0] answer;
      logic [1:0]           status;
   } outcome_type;

   anc_type              lift_tab [NODE_COUNT][LIFT_LEVELS];
   logic [DEPTH_BITS-1:0] depth_of [NODE_COUNT];
   logic [DIST_BITS-1:0] dist_of  [NODE_COUNT];
   logic                 on_tree  [NODE_COUNT];
   outcome_type          outcome_q[$];

   assign pending = outcome_q.size();

   function automatic node_type climb(node_type n, int steps);
      anc_type e;
      for (int l = LIFT_LEVELS - 1; l >= 0; l--) begin
         e = lift_tab[n][l];
         if (steps[l] && e.valid) n = e.node;
      end
      return n;
   endfunction

   function automatic node_type meet_node(node_type a, node_type b);
      node_type t;
      anc_type  ea, eb;
      if (depth_of[a] < depth_of[b]) begin
         t = a; a = b; b = t;
      end
      a = climb(a, int'(depth_of[a]) - int'(depth_of[b]));
      if (a == b) return a;
      for (int l = LIFT_LEVELS - 1; l >= 0; l--) begin
         ea = lift_tab[a][l];
         eb = lift_tab[b][l];
         if (ea != eb) begin
            if (ea.valid) a = ea.node;
            if (eb.valid) b = eb.node;
         end
      end
      return lift_tab[a][0].valid ? lift_tab[a][0].node : a;
   endfunction

   function automatic outcome_type evaluate(logic [1:0] cmd, node_type na, node_type nb,
                                            logic [WEIGHT_BITS-1:0] wt,
                                            logic [POS_BITS-1:0] pos);
      outcome_type r;
      node_type    l;
      longint      d;
      int          up_a, up_b, k;
      r = '0;
      case (cmd)
         CMD_START: begin
            for (int i = 0; i < NODE_COUNT; i++) on_tree[i] = 1'b0;
            on_tree[na] = 1'b1;
            depth_of[na] = '0;
            dist_of[na] = '0;
            for (int j = 0; j < LIFT_LEVELS; j++) lift_tab[na][j] = '0;
         end
         CMD_ATTACH: begin
            if (on_tree[na] || !on_tree[nb]) begin
               r.status = STATUS_UNATTACHED;
            end else begin
               d = longint'(dist_of[nb]) + wt;
               on_tree[na] = 1'b1;
               depth_of[na] = depth_of[nb] + 1'b1;
               dist_of[na] = (d > longint'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(d);
               lift_tab[na][0] = '{valid: 1'b1, node: nb};
               for (int j = 1; j < LIFT_LEVELS; j++)
                  lift_tab[na][j] = lift_tab[na][j-1].valid ?
                     lift_tab[lift_tab[na][j-1].node][j-1] : '0;
            end
         end
         default: begin
            if (!on_tree[na] || !on_tree[nb]) begin
               r.status = STATUS_UNATTACHED;
            end else begin
               l = meet_node(na, nb);
               if (cmd == CMD_DIST) begin
                  d = longint'(dist_of[na]) + dist_of[nb] - 2 * longint'(dist_of[l]);
                  r.answer = (d > longint'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(d);
               end else begin
                  up_a = int'(depth_of[na]) - int'(depth_of[l]);
                  up_b = int'(depth_of[nb]) - int'(depth_of[l]);
                  if (pos == 0 || int'(pos) > up_a + up_b + 1) begin
                     r.status = STATUS_RANGE;
                  end else begin
                     k = int'(pos) - 1;
                     r.answer = (k <= up_a) ? DIST_BITS'(climb(na, k))
                                            : DIST_BITS'(climb(nb, up_b - (k - up_a)));
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         errors <= 0;
         answered <= 0;
         outcome_q.delete();
         for (int i = 0; i < NODE_COUNT; i++) on_tree[i] = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            answered <= answered + 1;
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected response answer=%0d status=%0d", $time,
                        rsp_ch.answer, rsp_ch.status);
               errors <= errors + 1;
            end else begin
               want = outcome_q.pop_front();
               if (want.answer !== rsp_ch.answer || want.status !== rsp_ch.status) begin
                  $display("%0t: mismatch expected answer=%0d status=%0d, got answer=%0d status=%0d",
                           $time, want.answer, want.status, rsp_ch.answer, rsp_ch.status);
                  errors <= errors + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            outcome_q = {outcome_q, evaluate(req_ch.command, req_ch.node_a, req_ch.node_b,
                                             req_ch.edge_weight, req_ch.path_position)};
      end
   end

endmodule

`default_nettype wire

// ===== test/tree_ancestor_query_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_tb
// Builds random weighted trees parent-first and queries distances and k-th
// path nodes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query_engine_tb;
   import taqe_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, pending, answered;
   int   cycles = 0;
   int   hold_off = 0;
   int   sent = 0;
   bit   stim_done = 1'b0;

   taqe_req_if req_ch ();
   taqe_rsp_if rsp_ch ();

   // Nodes on the current tree, used to pick parents and endpoints.
   node_type members[$];

   tree_ancestor_query_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   tree_ancestor_query_engine_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .errors   (errors),
      .pending  (pending),
      .answered (answered)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_START;
      req_ch.node_a = '0;
      req_ch.node_b = '0;
      req_ch.edge_weight = '0;
      req_ch.path_position = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tree_ancestor_query_engine_tb: FAIL");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when asked.
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (w > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic send(logic [1:0] cmd, node_type na, node_type nb,
                       logic [WEIGHT_BITS-1:0] wt, logic [POS_BITS-1:0] pos, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
         req_ch.valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.node_a <= na;
      req_ch.node_b <= nb;
      req_ch.edge_weight <= wt;
      req_ch.path_position <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      if (cmd == CMD_START) begin
         members.delete();
         members = {members, na};
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic node_type pick_member();
      return members[$urandom_range(0, members.size() - 1)];
   endfunction

   function automatic node_type fresh_node();
      return node_type'($urandom_range(0, NODE_COUNT - 1));
   endfunction

   // Grow a random tree, then mix queries, attaches and noise on it.
   task automatic grow_and_query(int nodes, int queries, bit gaps);
      node_type c, p, a, b;
      logic [POS_BITS-1:0] pos;
      send(CMD_START, fresh_node(), fresh_node(), 16'($urandom), POS_BITS'($urandom), gaps);
      for (int i = 0; i < nodes; i++) begin
         c = fresh_node();
         p = ($urandom_range(0, 3) == 0) ? members[members.size() - 1] : pick_member();
         send(CMD_ATTACH, c, p, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
              POS_BITS'($urandom), gaps);
         if (!(c inside {members})) members = {members, c};
      end
      for (int i = 0; i < queries; i++) begin
         a = ($urandom_range(0, 15) == 0) ? fresh_node() : pick_member();
         b = ($urandom_range(0, 15) == 0) ? fresh_node() : pick_member();
         pos = ($urandom_range(0, 9) == 0) ? POS_BITS'($urandom) : POS_BITS'($urandom_range(0, 40));
         case ($urandom_range(0, 9))
            0: send(CMD_ATTACH, ($urandom_range(0, 1) ? pick_member() : fresh_node()),
                    ($urandom_range(0, 1) ? pick_member() : fresh_node()), 16'($urandom),
                    pos, gaps);
            1, 2, 3, 4: send(CMD_DIST, a, b, 16'($urandom), pos, gaps);
            default: send(CMD_KTH, a, b, 16'($urandom), pos, gaps);
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: queries before any tree, edge indexes, weight extremes,
      // attach of attached child and self, unattached parent, bad positions.
      send(CMD_DIST, 0, 0, 0, 1, 1'b0);
      send(CMD_START, 14'h3FFF, 0, 16'hFFFF, 15'h7FFF, 1'b0);
      send(CMD_ATTACH, 0, 14'h3FFF, 16'hFFFF, 0, 1'b0);
      send(CMD_ATTACH, 1, 0, 0, 0, 1'b0);
      send(CMD_ATTACH, 2, 1, 16'hFFFF, 0, 1'b0);
      send(CMD_ATTACH, 3, 14'h3FFF, 16'h5555, 0, 1'b0);
      send(CMD_ATTACH, 3, 3, 1, 0, 1'b0);
      send(CMD_ATTACH, 2, 0, 1, 0, 1'b0);
      send(CMD_ATTACH, 4, 9999, 1, 0, 1'b0);
      send(CMD_DIST, 2, 3, 0, 0, 1'b0);
      send(CMD_DIST, 14'h3FFF, 14'h3FFF, 0, 0, 1'b0);
      send(CMD_DIST, 2, 9999, 0, 0, 1'b0);
      send(CMD_KTH, 2, 3, 0, 0, 1'b0);
      send(CMD_KTH, 2, 3, 0, 1, 1'b0);
      send(CMD_KTH, 2, 3, 0, 3, 1'b0);
      send(CMD_KTH, 2, 3, 0, 5, 1'b0);
      send(CMD_KTH, 2, 3, 0, 6, 1'b0);
      send(CMD_KTH, 3, 2, 0, 15'h7FFF, 1'b0);
      send(CMD_KTH, 0, 14'h3FFF, 0, 15'h4000, 1'b0);
      send(CMD_START, 0, 0, 0, 0, 1'b0);
      send(CMD_DIST, 2, 0, 0, 0, 1'b0);

      // Hold off the response side so the engine backs up.
      drain();
      hold_off = 300;
      grow_and_query(10, 10, 1'b0);
      drain();

      // A deep chain to exercise the high lift levels.
      send(CMD_START, 100, 0, 0, 0, 1'b1);
      for (int i = 0; i < 60; i++) begin
         send(CMD_ATTACH, node_type'(101 + i), node_type'(100 + i), 16'($urandom), 0, 1'b1);
         members = {members, node_type'(101 + i)};
      end
      for (int i = 0; i < 40; i++)
         send(i[0] ? CMD_KTH : CMD_DIST, pick_member(), pick_member(), 0,
              POS_BITS'($urandom_range(0, 70)), 1'b1);
      drain();

      while (sent < 1600) begin
         grow_and_query($urandom_range(5, 60), $urandom_range(20, 80),
                        $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) drain();
      end
      drain();
      stim_done = 1'b1;
      repeat (200) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses over random trees,", sent, answered);
      $display("a deep chain and long response stalls; %0d mismatches.", errors);
      if (errors == 0 && pending == 0)
         $display("tree_ancestor_query_engine_tb: PASS");
      else
         $display("tree_ancestor_query_engine_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
